### rtl/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants for the channel column density block
// Sizes, mode/side/cfg codes, packed memory column and request records.
// ----------------------------------------------------------------------------
package ccd_pkg;
	localparam int MAX_COLS  = 256;
	localparam int MAX_DEPTH = 16;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_DEPTH);
	localparam int RCNT_W    = $clog2(MAX_DEPTH + 1);

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_PLACE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [1:0] SIDE_NONE   = 2'd0;
	localparam logic [1:0] SIDE_TOP    = 2'd1;
	localparam logic [1:0] SIDE_BOTTOM = 2'd2;

	localparam logic [1:0] CFG_COLS   = 2'd0;
	localparam logic [1:0] CFG_TROWS  = 2'd1;
	localparam logic [1:0] CFG_BROWS  = 2'd2;

	typedef struct packed {
		logic [MAX_DEPTH-1:0] top_occ;
		logic [MAX_DEPTH-1:0] bot_occ;
		logic [4:0]           top_deep;
		logic [4:0]           bot_deep;
		logic [15:0]          unplaced;
		logic [4:0]           top_off;
		logic [4:0]           bot_off;
	} col_rec_t;

	typedef struct packed {
		logic        prefers_top;
		logic [8:0]  right_col;
		logic [8:0]  left_col;
		logic [4:0]  bottom_indent;
		logic [4:0]  top_indent;
		logic [8:0]  column;
		logic [1:0]  mode;
	} req_t;
endpackage

### rtl/channel_column_density.sv
// ----------------------------------------------------------------------------
// channel_column_density: routing density per column with indented borders
// Places nets first-fit into top or bottom indentation rows, loads column
// indents, clears all columns and reports the density of a column on request.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: mode, column, top_indent, bottom_indent,
//                       left_col, right_col, prefers_top
//  m_axis    out        tdata: density, placed_side, placed_row
//  cfg       in         index 0 column_count, 1 top_rows, 2 bottom_rows
//
//  One column record memory, one read port and one write port, holds all
//  column state. After reset and after a clear request a clearing pass
//  writes MAX_COLS records, one a cycle; no request is taken then.
//  A read passes ST_RD, ST_RDW and ST_OUT, a load ST_RDW, ST_LDW and ST_OUT;
//  a load outside storage or a bad span goes straight to ST_OUT. A net
//  visits ST_NEXT per row and side tried and scans its span in ST_SCAN, up
//  to 2*MAX_DEPTH scans, then makes a write pass over the span in ST_MARK
//  (ST_FAIL if no row fits) and passes ST_OUT. A stalled result holds the
//  unit; the next request is taken once the result register is free.
// ----------------------------------------------------------------------------
module channel_column_density (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] mode, [10:2] column, [15:11] top_indent, [20:16] bottom_indent,
	// [29:21] left_col, [38:30] right_col, [39] prefers_top
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] density, [17:16] placed_side, [22:18] placed_row, [23] zero
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import ccd_pkg::*;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_RDW   = 4'd3;
	localparam logic [3:0] ST_LDW   = 4'd4;
	localparam logic [3:0] ST_SCAN  = 4'd5;
	localparam logic [3:0] ST_MARK  = 4'd6;
	localparam logic [3:0] ST_NEXT  = 4'd7;
	localparam logic [3:0] ST_FAIL  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	col_rec_t mem [MAX_COLS];
	col_rec_t rd_q;
	logic [COL_W-1:0] raddr;
	logic             we;
	logic [COL_W-1:0] waddr;
	col_rec_t         wdata;

	logic [3:0]  state_q;
	req_t        req_q;
	logic [8:0]  ncols_q;
	logic [4:0]  trows_q, brows_q;
	logic [COL_W:0] clr_q;
	logic [8:0]  k_q;
	logic [ROW_W:0] j_q;
	logic        side_top_q;
	logic        second_q;
	logic        ok_q;
	logic        rvalid_q;
	logic [8:0]  kr_q;
	logic [15:0] dens_q;
	logic [1:0]  pside_q;
	logic [4:0]  prow_q;
	logic        ovalid_q;

	req_t        req_in;
	logic [8:0]  ncols, ccol;
	logic [4:0]  trows, brows;
	logic [4:0]  side_rows;
	logic        cell_bad;
	logic [4:0]  tmax, bmax;
	logic [17:0] dsum;
	col_rec_t    upd;
	logic [MAX_DEPTH-1:0] jmask;

	assign req_in = req_t'(s_axis_tdata);
	assign ncols  = (ncols_q == 9'd0) ? 9'd1 :
	                (ncols_q > 9'(MAX_COLS)) ? 9'(MAX_COLS) : ncols_q;
	assign trows  = (trows_q > 5'(MAX_DEPTH)) ? 5'(MAX_DEPTH) : trows_q;
	assign brows  = (brows_q > 5'(MAX_DEPTH)) ? 5'(MAX_DEPTH) : brows_q;
	assign side_rows = side_top_q ? trows : brows;
	assign ccol   = (req_q.column == 9'd0) ? 9'd1 :
	                (req_q.column > ncols) ? ncols : req_q.column;
	assign jmask  = MAX_DEPTH'(1) << (j_q[ROW_W-1:0] - ROW_W'(1));

	assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {1'b0, prow_q, pside_q, dens_q};

	always_comb begin
		cell_bad = side_top_q ?
			(rd_q.top_occ[j_q[ROW_W-1:0]-ROW_W'(1)] || (5'(rd_q.top_off) >= 5'(j_q))) :
			(rd_q.bot_occ[j_q[ROW_W-1:0]-ROW_W'(1)] || (5'(rd_q.bot_off) >= 5'(j_q)));
		tmax = (rd_q.top_deep > rd_q.top_off) ? rd_q.top_deep : rd_q.top_off;
		bmax = (rd_q.bot_deep > rd_q.bot_off) ? rd_q.bot_deep : rd_q.bot_off;
		if (rd_q.unplaced == 16'd0)
			dsum = 18'(tmax) + 18'(bmax);
		else
			dsum = 18'(trows) + 18'(brows) + 18'(rd_q.unplaced);
		upd = rd_q;
		if (side_top_q) begin
			upd.top_occ = rd_q.top_occ | jmask;
			if (5'(j_q) > rd_q.top_deep) upd.top_deep = 5'(j_q);
		end else begin
			upd.bot_occ = rd_q.bot_occ | jmask;
			if (5'(j_q) > rd_q.bot_deep) upd.bot_deep = 5'(j_q);
		end
	end

	always_comb begin
		raddr = k_q[COL_W-1:0] - COL_W'(1);
		if (state_q == ST_RD) raddr = ccol[COL_W-1:0] - COL_W'(1);
		we    = 1'b0;
		waddr = kr_q[COL_W-1:0] - COL_W'(1);
		wdata = upd;
		case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q[COL_W-1:0];
				wdata = '0;
			end
			ST_LDW: begin
				we    = 1'b1;
				waddr = req_q.column[COL_W-1:0] - COL_W'(1);
				wdata = rd_q;
				wdata.top_off = req_q.top_indent;
				wdata.bot_off = req_q.bottom_indent;
			end
			ST_MARK: we = rvalid_q;
			ST_FAIL: begin
				we = rvalid_q;
				wdata = rd_q;
				if (rd_q.unplaced != 16'hFFFF) wdata.unplaced = rd_q.unplaced + 16'd1;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			ncols_q  <= 9'd1;
			trows_q  <= '0;
			brows_q  <= '0;
			ovalid_q <= 1'b0;
			rvalid_q <= 1'b0;
			k_q <= '0; kr_q <= '0; j_q <= '0;
			side_top_q <= 1'b0; second_q <= 1'b0; ok_q <= 1'b0;
			req_q <= '0;
			dens_q <= '0; pside_q <= '0; prow_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_COLS:  ncols_q <= cfg_data;
					CFG_TROWS: trows_q <= cfg_data[4:0];
					CFG_BROWS: brows_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			rvalid_q <= 1'b0;
			kr_q     <= k_q;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (COL_W+1)'(MAX_COLS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						req_q   <= req_in;
						dens_q  <= '0;
						pside_q <= SIDE_NONE;
						prow_q  <= '0;
						k_q     <= req_in.column;
						case (req_in.mode)
							MODE_LOAD: begin
								if (req_in.column >= 9'd1 && req_in.column <= 9'(MAX_COLS))
									state_q <= ST_RDW;
								else
									state_q <= ST_OUT;
							end
							MODE_READ: state_q <= ST_RD;
							MODE_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
								ovalid_q <= 1'b1;
							end
							default: begin
								if (req_in.left_col >= 9'd1 && req_in.right_col <= ncols &&
								    req_in.left_col <= req_in.right_col) begin
									side_top_q <= req_in.prefers_top;
									second_q   <= 1'b0;
									j_q        <= (ROW_W+1)'(1);
									k_q        <= req_in.left_col;
									ok_q       <= 1'b1;
									state_q    <= ST_NEXT;
								end else
									state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_RD: state_q <= ST_RDW;
				ST_RDW: begin
					if (req_q.mode == MODE_LOAD) state_q <= ST_LDW;
					else begin
						dens_q  <= (dsum > 18'hFFFF) ? 16'hFFFF : dsum[15:0];
						state_q <= ST_OUT;
					end
				end
				ST_LDW: state_q <= ST_OUT;
				ST_NEXT: begin
					if (5'(j_q) > side_rows) begin
						if (second_q) begin
							k_q     <= req_q.left_col;
							state_q <= ST_FAIL;
						end else begin
							second_q   <= 1'b1;
							side_top_q <= !side_top_q;
							j_q        <= (ROW_W+1)'(1);
						end
					end else begin
						k_q     <= req_q.left_col;
						ok_q    <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rvalid_q <= 1'b1;
					if (rvalid_q && cell_bad) ok_q <= 1'b0;
					if (k_q <= req_q.right_col) k_q <= k_q + 9'd1;
					else begin
						rvalid_q <= 1'b0;
						if (ok_q && !(rvalid_q && cell_bad)) begin
							k_q     <= req_q.left_col;
							pside_q <= side_top_q ? SIDE_TOP : SIDE_BOTTOM;
							prow_q  <= 5'(j_q);
							state_q <= ST_MARK;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_NEXT;
						end
					end
				end
				ST_MARK, ST_FAIL: begin
					rvalid_q <= 1'b1;
					if (k_q <= req_q.right_col) k_q <= k_q + 9'd1;
					else begin
						rvalid_q <= 1'b0;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("request taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !m_axis_tready) |=> ovalid_q) else $error("result dropped");
	a_side_row: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> ((pside_q == SIDE_NONE) == (prow_q == 5'd0))) else $error("side/row mismatch");
endmodule
